[hdl/sdavi_pkg.sv]
package sdavi_pkg;

	localparam int DATA_W = 32;
	localparam int FRAC_W = 20;
	localparam int STEP_W = 21;
	localparam int PROD_W = 2 * (DATA_W + 1);
	localparam int WIDE_W = 47;
	localparam logic [STEP_W-1:0] STEP_RESET = 21'd1048;
	localparam logic [3:0] WINDOW_END = 4'd11;
	localparam logic [3:0] LAST_IDX = 4'd14;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_USE,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL,
		OP_USE,
		OP_DONE
	} op_t;

	// command from controller to datapath
	typedef struct packed {
		op_t        op;
		logic [3:0] idx;
	} cmd_t;

	// saturate a wide signed value to the data range
	function automatic logic signed [DATA_W-1:0] sat_d(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
		lo = -hi - WIDE_W'(1);
		if (v > hi) begin
			sat_d = hi[DATA_W-1:0];
		end else if (v < lo) begin
			sat_d = lo[DATA_W-1:0];
		end else begin
			sat_d = v[DATA_W-1:0];
		end
	endfunction

	// next axis, wrapping after z
	function automatic logic [1:0] ax_next(input logic [1:0] a);
		ax_next = (a == 2'd2) ? 2'd0 : a + 2'd1;
	endfunction

endpackage

[hdl/sdavi_ctrl.sv]
module sdavi_ctrl
	import sdavi_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic [3:0] idx_q, idx_d;
	logic out_valid_q;
	logic done;

	// state and sequence index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		cmd.op = OP_NONE;
		cmd.idx = idx_q;
		in_ready = 1'b0;
		done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					idx_d = '0;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.op = OP_MUL;
				state_d = ST_USE;
			end
			ST_USE: begin
				cmd.op = OP_USE;
				if (idx_q == LAST_IDX) begin
					state_d = ST_OUT;
				end else begin
					idx_d = idx_q + 4'd1;
					state_d = ST_MUL;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.op = OP_DONE;
					done = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("item taken while busy");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (idx_q <= LAST_IDX))
		else $error("sequence index out of range");
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |=> (state_q == ST_USE))
		else $error("product not consumed");

endmodule

[hdl/sdavi_dp.sv]
module sdavi_dp
	import sdavi_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  logic [STEP_W-1:0] step_size,
	input  logic signed [DATA_W-1:0] rate_in [3],
	input  logic signed [DATA_W-1:0] coning_in [3],
	input  logic signed [DATA_W-1:0] force_in [3],
	output logic signed [DATA_W-1:0] angle_out [3],
	output logic signed [DATA_W-1:0] dvel_out [3]
);

	logic signed [DATA_W-1:0] sum_q [3];
	logic signed [DATA_W-1:0] force_q [3];
	logic signed [DATA_W-1:0] cross_q [3];
	logic signed [DATA_W-1:0] prev_rate_q [3];
	logic signed [DATA_W-1:0] prev_force_q [3];
	logic signed [DATA_W-1:0] prev_cross_q [3];
	logic signed [DATA_W-1:0] angle_q [3];
	logic signed [DATA_W-1:0] dvel_q [3];
	logic [3:0] count_q;
	logic signed [WIDE_W-1:0] t_q;
	logic signed [PROD_W-1:0] p_q;

	logic [3:0] rel;
	logic [1:0] ax;
	logic part;
	logic [1:0] ai, fi;
	logic signed [DATA_W:0] a_op, b_op;
	logic signed [PROD_W-1:0] r20, r21;
	logic signed [DATA_W:0] step_x;

	// decode sequence index into axis and part
	always_comb begin
		rel = '0;
		ax = cmd.idx[1:0];
		part = 1'b0;
		if (cmd.idx >= 4'd9) begin
			rel = cmd.idx - 4'd9;
			ax = rel[2:1];
			part = rel[0];
		end else if (cmd.idx >= 4'd3) begin
			rel = cmd.idx - 4'd3;
			ax = rel[2:1];
			part = rel[0];
		end
		ai = part ? ax_next(ax_next(ax)) : ax_next(ax);
		fi = part ? ax_next(ax) : ax_next(ax_next(ax));
	end

	assign step_x = {{(DATA_W + 1 - STEP_W){1'b0}}, step_size};

	// multiplier operand selection
	always_comb begin
		if (cmd.idx < 4'd3) begin
			a_op = {sum_q[ax][DATA_W-1], sum_q[ax]} + {prev_rate_q[ax][DATA_W-1], prev_rate_q[ax]};
			b_op = step_x;
		end else if (cmd.idx < 4'd9) begin
			a_op = {angle_q[ai][DATA_W-1], angle_q[ai]};
			b_op = {force_q[fi][DATA_W-1], force_q[fi]};
		end else if (!part) begin
			a_op = {force_q[ax][DATA_W-1], force_q[ax]}
				+ {prev_force_q[ax][DATA_W-1], prev_force_q[ax]};
			b_op = step_x;
		end else begin
			a_op = {cross_q[ax][DATA_W-1], cross_q[ax]}
				+ {prev_cross_q[ax][DATA_W-1], prev_cross_q[ax]};
			b_op = step_x;
		end
	end

	// rounded shifts of the product, ties upward
	assign r20 = (p_q + (PROD_W'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
	assign r21 = (p_q + (PROD_W'(1) <<< FRAC_W)) >>> (FRAC_W + 1);

	// shared multiplier
	always_ff @(posedge clk) begin
		if (cmd.op == OP_MUL) begin
			p_q <= a_op * b_op;
		end
	end

	// input latch and per-item samples
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= sat_d(WIDE_W'(rate_in[i]) + WIDE_W'(coning_in[i]));
				force_q[i] <= force_in[i];
			end
		end
		if (cmd.op == OP_USE && cmd.idx >= 4'd3 && cmd.idx < 4'd9 && part) begin
			cross_q[ax] <= sat_d(t_q - r20[WIDE_W-1:0]);
		end
		if (cmd.op == OP_USE) begin
			if (cmd.idx >= 4'd3 && cmd.idx < 4'd9 && !part) begin
				t_q <= r20[WIDE_W-1:0];
			end else if (cmd.idx >= 4'd9 && !part) begin
				t_q <= r21[WIDE_W-1:0];
			end
		end
	end

	// state held across items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				prev_rate_q[i] <= '0;
				prev_force_q[i] <= '0;
				prev_cross_q[i] <= '0;
				angle_q[i] <= '0;
				dvel_q[i] <= '0;
			end
			count_q <= '0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					if (count_q == WINDOW_END) begin
						for (int i = 0; i < 3; i++) begin
							angle_q[i] <= '0;
							dvel_q[i] <= '0;
						end
						count_q <= 4'd2;
					end else begin
						count_q <= count_q + 4'd1;
					end
				end
				OP_USE: begin
					if (cmd.idx < 4'd3) begin
						angle_q[ax] <= sat_d(WIDE_W'(angle_q[ax]) + r21[WIDE_W-1:0]);
						prev_rate_q[ax] <= sum_q[ax];
					end else if (cmd.idx >= 4'd9 && part) begin
						dvel_q[ax] <= sat_d(WIDE_W'(dvel_q[ax]) + t_q + r21[WIDE_W-1:0]);
						prev_force_q[ax] <= force_q[ax];
						prev_cross_q[ax] <= cross_q[ax];
					end
				end
				default: ;
			endcase
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.op == OP_DONE) begin
			angle_out <= angle_q;
			dvel_out <= dvel_q;
		end
	end

endmodule

[hdl/strapdown_angle_velocity_integrator.sv]
// Strapdown angle and velocity integrator.
// Input channel (in_valid/in_ready) carries body rate, coning correction and
// specific force for three axes, signed Q12.20. Output channel
// (out_valid/out_ready) carries the window angle and velocity accumulators.
// One shared 33x33 multiplier does fifteen products per item, each in a
// multiply state (operand select and multiply) followed by a use state
// (round and accumulate). An output state then loads the result register.
// A new item is taken only once the last one has finished its arithmetic.
// The result sits in an output register; a new item may be accepted while it
// waits. If the receiver stalls, the next item finishes its arithmetic and
// then waits until the held result is taken.
// The accumulators clear at the start of the twelfth item after reset, then every tenth item.
// step_size is written over the APB port at address 0 (reset 1048, Q1.20);
// the user must do so only while idle; the block does not enforce this.
// Reset clears all history, the accumulators and the step count; no
// clearing pass is needed.
module strapdown_angle_velocity_integrator
	import sdavi_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [0:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [DATA_W-1:0] rate_x,
	input  logic signed [DATA_W-1:0] rate_y,
	input  logic signed [DATA_W-1:0] rate_z,
	input  logic signed [DATA_W-1:0] coning_x,
	input  logic signed [DATA_W-1:0] coning_y,
	input  logic signed [DATA_W-1:0] coning_z,
	input  logic signed [DATA_W-1:0] force_x,
	input  logic signed [DATA_W-1:0] force_y,
	input  logic signed [DATA_W-1:0] force_z,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [DATA_W-1:0] angle_x,
	output logic signed [DATA_W-1:0] angle_y,
	output logic signed [DATA_W-1:0] angle_z,
	output logic signed [DATA_W-1:0] dvel_x,
	output logic signed [DATA_W-1:0] dvel_y,
	output logic signed [DATA_W-1:0] dvel_z
);

	logic [STEP_W-1:0] step_q;
	cmd_t cmd;
	logic signed [DATA_W-1:0] rate_in [3];
	logic signed [DATA_W-1:0] coning_in [3];
	logic signed [DATA_W-1:0] force_in [3];
	logic signed [DATA_W-1:0] angle_out [3];
	logic signed [DATA_W-1:0] dvel_out [3];

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (psel && penable && pwrite && paddr == 1'b0) begin
			step_q <= pwdata[STEP_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == 1'b0) ? {{(32 - STEP_W){1'b0}}, step_q} : 32'd0;

	assign rate_in = '{rate_x, rate_y, rate_z};
	assign coning_in = '{coning_x, coning_y, coning_z};
	assign force_in = '{force_x, force_y, force_z};

	sdavi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	sdavi_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.step_size (step_q),
		.rate_in   (rate_in),
		.coning_in (coning_in),
		.force_in  (force_in),
		.angle_out (angle_out),
		.dvel_out  (dvel_out)
	);

	assign angle_x = angle_out[0];
	assign angle_y = angle_out[1];
	assign angle_z = angle_out[2];
	assign dvel_x = dvel_out[0];
	assign dvel_y = dvel_out[1];
	assign dvel_z = dvel_out[2];

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
	import sdavi_pkg::*;

	typedef logic [8:0][DATA_W-1:0] sample_t;
	typedef logic [5:0][DATA_W-1:0] window_t;

	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT = 3000;
	localparam logic [0:0] ADDR_STEP = 1'b0;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [0:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready, out_valid, out_ready;
	sample_t smp;
	logic signed [DATA_W-1:0] angle_x, angle_y, angle_z, dvel_x, dvel_y, dvel_z;

	sample_t pending_samples[$];
	window_t expected_windows[$];
	logic in_taken, hold_rx;
	int sender_idle, receiver_idle, errors, quiet_cycles;

	// integrator model state
	longint step_q20;
	longint prev_rate_sum[3], angle_acc[3], prev_force[3], prev_cross[3], dvel_acc[3];
	int window_count;

	strapdown_angle_velocity_integrator DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.rate_x(smp[0]), .rate_y(smp[1]), .rate_z(smp[2]),
		.coning_x(smp[3]), .coning_y(smp[4]), .coning_z(smp[5]),
		.force_x(smp[6]), .force_y(smp[7]), .force_z(smp[8]),
		.out_valid(out_valid), .out_ready(out_ready),
		.angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
		.dvel_x(dvel_x), .dvel_y(dvel_y), .dvel_z(dvel_z)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end else if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// add half, then floor
	function automatic longint round_down(longint v, int sh);
		return (v + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint trapezoid(longint now_v, longint old_v);
		return round_down((now_v + old_v) * step_q20, FRAC_W + 1);
	endfunction

	function automatic longint cross_part(longint a, longint b, longint c, longint d);
		return sat32(round_down(a * b, FRAC_W) - round_down(c * d, FRAC_W));
	endfunction

	// one integration step; updates the model state
	function window_t integrate_sample(sample_t s);
		longint f[3], cr[3], rsum, add;
		window_t w;
		if (window_count == 11) begin
			window_count = 1;
			for (int i = 0; i < 3; i++) begin
				angle_acc[i] = 0;
				dvel_acc[i] = 0;
			end
		end
		for (int i = 0; i < 3; i++) begin
			rsum = sat32(longint'($signed(s[i])) + longint'($signed(s[3+i])));
			angle_acc[i] = sat32(angle_acc[i] + trapezoid(rsum, prev_rate_sum[i]));
			prev_rate_sum[i] = rsum;
			f[i] = longint'($signed(s[6+i]));
		end
		cr[0] = cross_part(angle_acc[1], f[2], angle_acc[2], f[1]);
		cr[1] = cross_part(angle_acc[2], f[0], angle_acc[0], f[2]);
		cr[2] = cross_part(angle_acc[0], f[1], angle_acc[1], f[0]);
		for (int i = 0; i < 3; i++) begin
			add = trapezoid(f[i], prev_force[i]) + trapezoid(cr[i], prev_cross[i]);
			dvel_acc[i] = sat32(dvel_acc[i] + add);
			prev_force[i] = f[i];
			prev_cross[i] = cr[i];
		end
		window_count = (window_count + 1) & 15;
		for (int i = 0; i < 3; i++) begin
			w[i] = angle_acc[i][31:0];
			w[3+i] = dvel_acc[i][31:0];
		end
		return w;
	endfunction

	task automatic report(string what, logic [31:0] want, logic [31:0] got);
		errors++;
		if (errors <= 10) begin
			$display("%0t %s: expected %0d got %0d", $realtime, what,
				$signed(want), $signed(got));
		end
	endtask

	// acceptance tracking, prediction and result checking
	always @(posedge clk) begin
		window_t want, got;
		in_taken <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			expected_windows.push_back(integrate_sample(smp));
		end
		if (out_valid && out_ready) begin
			got = {dvel_z, dvel_y, dvel_x, angle_z, angle_y, angle_x};
			if (expected_windows.size() == 0) begin
				report("unexpected item", '0, got[0]);
			end else begin
				want = expected_windows.pop_front();
				for (int i = 0; i < 6; i++) begin
					if (got[i] !== want[i]) begin
						report(i < 3 ? $sformatf("angle[%0d]", i)
							: $sformatf("dvel[%0d]", i - 3), want[i], got[i]);
					end
				end
			end
		end
	end

	// sender
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_samples.size() > 0 && $urandom_range(99) >= sender_idle) begin
				smp <= pending_samples.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (arst_n) begin
			out_ready <= !hold_rx && ($urandom_range(99) >= receiver_idle);
		end
	end

	// long receiver hold-off
	always begin
		wait (hold_rx);
		repeat (HOLD_CYCLES) @(posedge clk);
		@(negedge clk);
		hold_rx = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_step(logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_STEP; pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		step_q20 = longint'(v[STEP_W-1:0]);
		// read back
		@(negedge clk);
		penable <= 1'b0; pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[STEP_W-1:0] !== v[STEP_W-1:0]) begin
			report("step_size readback", {11'd0, v[STEP_W-1:0]}, prdata);
		end
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0;
	endtask

	// wait until every item has gone through and the block is quiet
	task automatic drain();
		while (pending_samples.size() > 0 || in_valid || expected_windows.size() > 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_field();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return 32'($urandom_range(32'h0200_0000) - 32'h0100_0000);
			5, 6, 7: return $urandom;
			8: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
		endcase
	endfunction

	task automatic queue_random(int n);
		sample_t s;
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < 9; i++) begin
				s[i] = rand_field();
			end
			pending_samples.push_back(s);
		end
	endtask

	initial begin
		sample_t s;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_valid = 1'b0; out_ready = 1'b0; smp = '0;
		in_taken = 1'b0; hold_rx = 1'b0;
		errors = 0; quiet_cycles = 0;
		step_q20 = longint'(STEP_RESET);
		window_count = 0;
		for (int i = 0; i < 3; i++) begin
			prev_rate_sum[i] = 0; angle_acc[i] = 0; prev_force[i] = 0;
			prev_cross[i] = 0; dvel_acc[i] = 0;
		end
		sender_idle = 29;
		receiver_idle = 62;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: largest step, upper bits of the write data ignored
		write_step(32'hFFFF_FFFF);
		s = '0;
		pending_samples.push_back(s);
		s = {9{32'h7FFF_FFFF}};
		pending_samples.push_back(s);
		s = {9{32'h8000_0000}};
		pending_samples.push_back(s);
		s = {9{32'h7FFF_FFFF}};
		pending_samples.push_back(s);
		s = {9{32'hFFFF_FFFF}};
		pending_samples.push_back(s);
		for (int k = 0; k < 17; k++) begin
			// small rates and forces run across a window end
			for (int i = 0; i < 9; i++) begin
				s[i] = 32'((k + 1) * (i + 3) * 32'sd40000 * ((i + k) % 2 ? -1 : 1));
			end
			pending_samples.push_back(s);
		end
		drain();

		// phase one, with the receiver held off at the start
		write_step(32'hABC0_0000 | 32'd1048);
		@(negedge clk);
		hold_rx = 1'b1;
		queue_random(400);
		drain();

		write_step(32'd0);
		queue_random(30);
		drain();

		// phase two
		sender_idle = 62;
		receiver_idle = 29;
		write_step($urandom_range(32'h001F_FFFF));
		queue_random(400);
		drain();

		// phase three: unit step, no idling
		sender_idle = 0;
		receiver_idle = 0;
		write_step(32'd1048576);
		queue_random(400);
		drain();

		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
